// ===== sv/first_order_compensator_hbridge_pwm_defines.svh =====
// Assertion macros shared by the compensator RTL.
`ifndef FIRST_ORDER_COMPENSATOR_HBRIDGE_PWM_DEFINES_SVH
`define FIRST_ORDER_COMPENSATOR_HBRIDGE_PWM_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define FCOMP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fcomp: same-cycle check failed");
// Next-cycle implication, disabled while in reset.
`define FCOMP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fcomp: next-cycle check failed");
`else
`define FCOMP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FCOMP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/fcomp_pkg.sv =====
// Shared constants, codes and command type of the compensator.
`timescale 1ns / 1ps
package fcomp_pkg;

    localparam int GAIN_W     = 16;  // Q3.12 gain registers
    localparam int CTRL_W     = 21;  // stored control value, signed
    localparam int CMP_W      = 10;  // PWM compare output fields
    localparam int CTRL_LIMIT = (1 << 20) - 1;
    localparam int CFG_IDX_W  = 2;

    localparam int PWM_PERIOD_COUNTS_DEF  = 1000;
    localparam int SAMPLE_BITS_DEF        = 12;
    localparam int COEF_FRACTION_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ERROR_NOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ERROR_LAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CONTROL_LAST = 2'd2;

    // multiplier operand pairs
    localparam logic [1:0] MUL_C0_ERR   = 2'd0;
    localparam logic [1:0] MUL_C1_LERR  = 2'd1;
    localparam logic [1:0] MUL_D1_LCTRL = 2'd2;
    localparam logic [1:0] MUL_PER_MAG  = 2'd3;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef struct packed {
        logic       capture;
        logic [1:0] mul_sel;
        logic [1:0] acc_op;
        logic       clip;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } fcomp_cmd_t;

endpackage

// ===== sv/fcomp_dp.sv =====
// Datapath: gain registers, shared multiplier, accumulator, clip and duty divider.
`timescale 1ns / 1ps
`include "first_order_compensator_hbridge_pwm_defines.svh"
module fcomp_dp import fcomp_pkg::*; #(
    parameter int PWM_PERIOD_COUNTS  = PWM_PERIOD_COUNTS_DEF,
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int COEF_FRACTION_BITS = COEF_FRACTION_BITS_DEF,
    localparam int S_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * CMP_W + 1 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0]     cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  fcomp_cmd_t            cmd,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int EW    = SAMPLE_BITS + 1;
    localparam int PB    = $clog2(PWM_PERIOD_COUNTS + 1);
    localparam int QB    = $clog2(PWM_PERIOD_COUNTS);
    localparam int AW    = (PB + 1 > GAIN_W) ? PB + 1 : GAIN_W;
    localparam int BW    = (CTRL_W > EW) ? CTRL_W : EW;
    localparam int PW    = AW + BW;
    localparam int ACC_W = PW + 2;
    localparam int FS    = (1 << SAMPLE_BITS) - 1;
    localparam int XW    = PB + SAMPLE_BITS;
    localparam int RW    = ((PB > SAMPLE_BITS) ? PB : SAMPLE_BITS) + 1;

    localparam logic signed [ACC_W-1:0] LIM_P = ACC_W'(CTRL_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_N = -LIM_P;

    logic signed [GAIN_W-1:0] gain0_reg, gain1_reg, gaind_reg;
    logic signed [EW-1:0]     err_reg, err_next;
    logic signed [EW-1:0]     last_err_reg;
    logic signed [CTRL_W-1:0] last_ctrl_reg;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [PW-1:0]     prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  u_shift;
    logic signed [CTRL_W-1:0] u_clip;
    logic                     clip_hit, u_pos;
    logic [CTRL_W-1:0]        mag_c, mag_reg;
    logic                     full_c, full_reg, pos_reg, sat_reg;
    logic [XW-1:0]            div_x;
    logic [RW-1:0]            rem_reg, rem_next;
    logic [QB-1:0]            quo_reg, quo_next, quo_fin;
    logic [CMP_W-1:0]         cmp_val;
    logic [CMP_W-1:0]         fwd_reg, rev_reg;
    logic                     osat_reg;

    // gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain0_reg <= '0;
            gain1_reg <= '0;
            gaind_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GAIN_ERROR_NOW:    gain0_reg <= cfg_wdata;
                REG_GAIN_ERROR_LAST:   gain1_reg <= cfg_wdata;
                REG_GAIN_CONTROL_LAST: gaind_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign err_next = EW'({1'b0, s_tdata[SAMPLE_BITS-1:0]})
                    - EW'({1'b0, s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]});

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_C0_ERR: begin
                mul_a = AW'(gain0_reg);
                mul_b = BW'(err_reg);
            end
            MUL_C1_LERR: begin
                mul_a = AW'(gain1_reg);
                mul_b = BW'(last_err_reg);
            end
            MUL_D1_LCTRL: begin
                mul_a = AW'(gaind_reg);
                mul_b = BW'(last_ctrl_reg);
            end
            default: begin
                mul_a = AW'(PWM_PERIOD_COUNTS);
                mul_b = BW'(signed'(mag_reg));
            end
        endcase
    end

    // floor shift out of Q format, then clip to the control limit
    always_comb begin
        u_shift  = acc_reg >>> COEF_FRACTION_BITS;
        clip_hit = 1'b0;
        if (u_shift > LIM_P) begin
            u_clip   = CTRL_W'(LIM_P);
            clip_hit = 1'b1;
        end else if (u_shift < LIM_N) begin
            u_clip   = CTRL_W'(LIM_N);
            clip_hit = 1'b1;
        end else begin
            u_clip = CTRL_W'(u_shift);
        end
        u_pos  = (u_clip > 0);
        mag_c  = u_pos ? unsigned'(u_clip) : unsigned'(-u_clip);
        full_c = (mag_c >= CTRL_W'(FS));
    end

    // PERIOD*mag / (2^n - 1): each fold moves the bits above n into the quotient
    // and adds them back onto the low bits; a leftover of full scale is one more
    always_comb begin
        div_x    = prod_reg[XW-1:0];
        quo_next = quo_reg + QB'(rem_reg[RW-1:SAMPLE_BITS]);
        rem_next = RW'(rem_reg[RW-1:SAMPLE_BITS]) + RW'(rem_reg[SAMPLE_BITS-1:0]);
        quo_fin  = quo_reg + QB'(rem_reg == RW'(FS));
        cmp_val  = full_reg ? CMP_W'(PWM_PERIOD_COUNTS - 1) : CMP_W'(quo_fin);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture) begin
            err_reg <= err_next;
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - ACC_W'(prod_reg);
            default:  ;
        endcase
        if (cmd.clip) begin
            pos_reg  <= u_pos;
            full_reg <= full_c;
            sat_reg  <= clip_hit | full_c;
        end
        if (cmd.div_init) begin
            quo_reg <= QB'(div_x[XW-1:SAMPLE_BITS]);
            rem_reg <= RW'(div_x[XW-1:SAMPLE_BITS]) + RW'(div_x[SAMPLE_BITS-1:0]);
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // loop state and output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            last_ctrl_reg <= '0;
            mag_reg       <= '0;
            fwd_reg       <= '0;
            rev_reg       <= '0;
            osat_reg      <= 1'b0;
        end else begin
            if (cmd.clip) begin
                last_err_reg  <= err_reg;
                last_ctrl_reg <= u_clip;
                mag_reg       <= mag_c;
            end
            if (cmd.out_load) begin
                fwd_reg  <= pos_reg ? cmp_val : '0;
                rev_reg  <= pos_reg ? '0 : cmp_val;
                osat_reg <= sat_reg;
            end
        end
    end

    assign m_tdata = M_DATA_W'({osat_reg, rev_reg, fwd_reg});

    `FCOMP_ASSERT_IMP(a_mag_limit, aclk, aresetn, 1'b1, mag_reg <= CTRL_W'(CTRL_LIMIT))
    `FCOMP_ASSERT_IMP(a_one_side, aclk, aresetn, fwd_reg != '0, rev_reg == '0)
    `FCOMP_ASSERT_IMP(a_rem_range, aclk, aresetn, cmd.out_load && !full_reg, rem_reg <= RW'(FS))

endmodule

// ===== sv/fcomp_ctrl.sv =====
// Sequencer: steps one sample through multiply, clip and divide, owns the handshakes.
`timescale 1ns / 1ps
`include "first_order_compensator_hbridge_pwm_defines.svh"
module fcomp_ctrl import fcomp_pkg::*; #(
    parameter int PWM_PERIOD_COUNTS = PWM_PERIOD_COUNTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output fcomp_cmd_t cmd
);

    localparam int QB = $clog2(PWM_PERIOD_COUNTS);
    localparam int CW = $clog2(QB + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_SUB   = 4'd4;
    localparam logic [3:0] S_CLIP  = 4'd5;
    localparam logic [3:0] S_PMUL  = 4'd6;
    localparam logic [3:0] S_DINIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PER_MAG;
        cmd.acc_op  = ACC_HOLD;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL0;
                end
            end
            S_MUL0: begin
                cmd.mul_sel = MUL_C0_ERR;
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_sel = MUL_C1_LERR;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_sel = MUL_D1_LCTRL;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_SUB;
            end
            S_SUB: begin
                cmd.acc_op = ACC_SUB;
                state_next = S_CLIP;
            end
            S_CLIP: begin
                cmd.clip   = 1'b1;
                state_next = S_PMUL;
            end
            S_PMUL: begin
                cmd.mul_sel = MUL_PER_MAG;
                state_next  = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QB - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `FCOMP_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == S_MUL0)
    `FCOMP_ASSERT_NXT(a_done_waits, aclk, aresetn,
        state_reg == S_DONE && m_tvalid_reg && !m_tready, state_reg == S_DONE)
    `FCOMP_ASSERT_IMP(a_div_count, aclk, aresetn, state_reg == S_DIV, cnt_reg < CW'(QB))
    `FCOMP_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.out_load, slot_free)

endmodule

// ===== sv/first_order_compensator_hbridge_pwm.sv =====
// Top level: first-order compensator driving forward and reverse PWM compares.
//
// Input stream (s_): one beat carries a reference and a feedback sample in
// converter counts. The block forms e = ref - fb, evaluates
// u = c0*e + c1*e_prev - d1*u_prev in Q3.12 (floor), clips u to +/-(2^20-1)
// and scales |u| to a compare of PERIOD*|u|/(2^SAMPLE_BITS-1), capped at
// PERIOD-1. Positive u drives the forward compare, otherwise the reverse one.
// Output stream (m_): one beat per input beat with both compares and a
// saturation flag. Gains are written through the cfg_ port; the user must
// write them only while idle, since the block itself does not enforce it.
// One shared multiplier takes the three products and the duty scaling, and
// the division by full scale runs one fold per cycle, and a new input beat is
// taken only after the previous result has been loaded into the output
// register. A finished beat sits in the output register while the next
// input beat is accepted; if the receiver stalls, the next result waits in
// its last state until the output register frees. Reset clears gains, the
// previous error and control, and the output valid.
`timescale 1ns / 1ps
module first_order_compensator_hbridge_pwm import fcomp_pkg::*; #(
    parameter int PWM_PERIOD_COUNTS  = PWM_PERIOD_COUNTS_DEF,
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int COEF_FRACTION_BITS = COEF_FRACTION_BITS_DEF,
    localparam int S_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * CMP_W + 1 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,  // reference_sample, feedback_sample, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata   // forward_compare, reverse_compare, saturated, pad
);

    fcomp_cmd_t cmd;

    fcomp_ctrl #(
        .PWM_PERIOD_COUNTS(PWM_PERIOD_COUNTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fcomp_dp #(
        .PWM_PERIOD_COUNTS (PWM_PERIOD_COUNTS),
        .SAMPLE_BITS       (SAMPLE_BITS),
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule
